// ===== sv/assert_macros.svh =====
// Assertion macros shared by the ramp generator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, off during reset.
`define TRG_ASSERT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
    else $error(msg);
// Next-cycle implication, off during reset.
`define TRG_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
    else $error(msg);
`else
`define TRG_ASSERT(label, clk, rst_n, cond, prop, msg)
`define TRG_ASSERT_NEXT(label, clk, rst_n, cond, prop, msg)
`endif
`endif

// ===== sv/trg_pkg.sv =====
// Types and constants of the triggered ramp generator.
package trg_pkg;

    localparam int MV_BITS       = 15;
    localparam int BASE_BITS     = 34;
    localparam int GAIN_BITS     = 21;
    localparam int PERIOD_BITS   = 20;
    localparam int DUR_BITS      = 34;
    localparam int ACC_BITS      = 38;
    localparam int MUL_STEPS     = MV_BITS;
    localparam int CFG_IDX_BITS  = 2;
    localparam int CFG_DATA_BITS = 34;

    localparam logic [DUR_BITS-1:0]       MAX_DUR_NS   = 34'd10000000000;
    localparam logic signed [MV_BITS-1:0] TRIG_HIGH_MV = 15'sd2000;
    localparam logic signed [MV_BITS-1:0] TRIG_LOW_MV  = 15'sd100;

    localparam logic [BASE_BITS-1:0]   BASE_RESET   = 34'd5000000000;
    localparam logic [PERIOD_BITS-1:0] PERIOD_RESET = 20'd20833;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_BASE   = 2'd0,
        REG_GAIN   = 2'd1,
        REG_PERIOD = 2'd2
    } cfg_reg_t;

    typedef struct packed {
        logic start;
    } div_ctl_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

// ===== sv/trg_in_if.sv =====
// Input item channel: trigger and control voltages.
interface trg_in_if import trg_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [MV_BITS-1:0] trig_mv;
    logic signed [MV_BITS-1:0] cv_mv;

    modport source (output valid, trig_mv, cv_mv, input ready);
    modport sink (input valid, trig_mv, cv_mv, output ready);
endinterface

// ===== sv/trg_out_if.sv =====
// Result item channel: ramp level and gate.
interface trg_out_if #(
    parameter int RAMP_BITS = 16
) ();
    logic                 valid;
    logic                 ready;
    logic [RAMP_BITS-1:0] ramp_level;
    logic                 gate;

    modport source (output valid, ramp_level, gate, input ready);
    modport sink (input valid, ramp_level, gate, output ready);
endinterface

// ===== sv/trg_cfg_if.sv =====
// Register write channel.
interface trg_cfg_if import trg_pkg::*; ();
    logic                     valid;
    logic                     ready;
    logic [CFG_IDX_BITS-1:0]  index;
    logic [CFG_DATA_BITS-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ===== sv/triggered_ramp_generator.sv =====
// Triggered ramp generator: each item is accepted, then the shift-add product
// cv_mv * cv_gain_ns_per_mv sets the duration, the trigger, elapsed-time and gate are
// updated, and, while the gate is high, the bit-serial ramp divider is started and run;
// then the result is handed to the output register once that register is free. The
// result register frees the engine, so a new item is taken while the previous result
// waits. Register writes are taken in any cycle.
`include "assert_macros.svh"
module triggered_ramp_generator import trg_pkg::*; #(
    parameter int RAMP_BITS = 16,
    parameter int TIME_BITS = 40
) (
    input  logic       clk,
    input  logic       rst_n,
    trg_in_if.sink     sample,
    trg_out_if.source  result,
    trg_cfg_if.sink    cfg
);

    localparam int CNT_BITS = $clog2(MUL_STEPS);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_MUL   = 6'b000010,
        S_STEP  = 6'b000100,
        S_DIVST = 6'b001000,
        S_DIV   = 6'b010000,
        S_FIN   = 6'b100000
    } state_t;

    state_t                         state_reg, state_next;
    logic [BASE_BITS-1:0]           base_reg, base_next;
    logic signed [GAIN_BITS-1:0]    gain_reg, gain_next;
    logic [PERIOD_BITS-1:0]         period_reg, period_next;
    logic                           schmitt_reg, schmitt_next;
    logic                           edge_reg, edge_next;
    logic [TIME_BITS-1:0]           elapsed_reg, elapsed_next;
    logic                           active_reg, active_next;
    logic [CNT_BITS-1:0]            cnt_reg, cnt_next;
    logic [MV_BITS-1:0]             cv_reg, cv_next;
    logic signed [ACC_BITS-1:0]     acc_reg, acc_next;
    logic signed [ACC_BITS-1:0]     mcand_reg, mcand_next;
    logic [DUR_BITS-1:0]            dur_reg, dur_next;
    logic                           out_valid_reg, out_valid_next;
    logic [RAMP_BITS-1:0]           ramp_reg, ramp_next;
    logic                           gate_reg, gate_next;

    logic                           take;
    logic                           restart;
    logic [TIME_BITS-1:0]           time_start;
    logic [TIME_BITS:0]             time_sum;
    logic [TIME_BITS-1:0]           time_new;
    logic [DUR_BITS-1:0]            dur_clamped;
    div_ctl_t                       div_ctl;
    div_stat_t                      div_stat;
    logic [RAMP_BITS-1:0]           div_quot;

    assign take = sample.valid && sample.ready;

    // clamp the signed duration sum to 0..10 s
    always_comb
    begin
        priority if (acc_reg[ACC_BITS-1])
        begin
            dur_clamped = '0;
        end
        else if (acc_reg[ACC_BITS-2:0] > (ACC_BITS-1)'(MAX_DUR_NS))
        begin
            dur_clamped = MAX_DUR_NS;
        end
        else
        begin
            dur_clamped = acc_reg[DUR_BITS-1:0];
        end
    end

    assign restart    = edge_reg && (dur_clamped != '0);
    assign time_start = restart ? '0 : elapsed_reg;
    assign time_sum   = {1'b0, time_start} + (TIME_BITS+1)'(period_reg);
    assign time_new   = time_sum[TIME_BITS] ? '1 : time_sum[TIME_BITS-1:0];

    always_comb
    begin
        state_next     = state_reg;
        schmitt_next   = schmitt_reg;
        edge_next      = edge_reg;
        elapsed_next   = elapsed_reg;
        active_next    = active_reg;
        cnt_next       = cnt_reg;
        cv_next        = cv_reg;
        acc_next       = acc_reg;
        mcand_next     = mcand_reg;
        dur_next       = dur_reg;
        out_valid_next = out_valid_reg;
        ramp_next      = ramp_reg;
        gate_next      = gate_reg;
        div_ctl.start  = 1'b0;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (take)
                begin
                    edge_next = 1'b0;
                    if (schmitt_reg)
                    begin
                        if (sample.trig_mv <= TRIG_LOW_MV)
                        begin
                            schmitt_next = 1'b0;
                        end
                    end
                    else if (sample.trig_mv >= TRIG_HIGH_MV)
                    begin
                        schmitt_next = 1'b1;
                        edge_next    = 1'b1;
                    end
                    cv_next    = sample.cv_mv;
                    acc_next   = ACC_BITS'(base_reg);
                    mcand_next = ACC_BITS'(gain_reg);
                    cnt_next   = '0;
                    state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                // top bit of the control voltage carries negative weight
                if (cv_reg[0])
                begin
                    acc_next = (cnt_reg == CNT_BITS'(MUL_STEPS - 1)) ? acc_reg - mcand_reg
                                                                      : acc_reg + mcand_reg;
                end
                mcand_next = mcand_reg <<< 1;
                cv_next    = cv_reg >> 1;
                cnt_next   = cnt_reg + 1'b1;
                if (cnt_reg == CNT_BITS'(MUL_STEPS - 1))
                begin
                    state_next = S_STEP;
                end
            end
            S_STEP:
            begin
                dur_next     = dur_clamped;
                elapsed_next = time_new;
                active_next  = (active_reg || restart)
                               && (time_new < TIME_BITS'(dur_clamped));
                state_next   = (active_next) ? S_DIVST : S_FIN;
            end
            S_DIVST:
            begin
                div_ctl.start = 1'b1;
                state_next    = S_DIV;
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    out_valid_next = 1'b1;
                    gate_next      = active_reg;
                    ramp_next      = active_reg ? div_quot : '0;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        base_next   = base_reg;
        gain_next   = gain_reg;
        period_next = period_reg;
        if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_BASE:   base_next   = cfg.data[BASE_BITS-1:0];
                REG_GAIN:   gain_next   = cfg.data[GAIN_BITS-1:0];
                REG_PERIOD: period_next = cfg.data[PERIOD_BITS-1:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            base_reg      <= BASE_RESET;
            gain_reg      <= '0;
            period_reg    <= PERIOD_RESET;
            schmitt_reg   <= 1'b0;
            edge_reg      <= 1'b0;
            elapsed_reg   <= '0;
            active_reg    <= 1'b0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            base_reg      <= base_next;
            gain_reg      <= gain_next;
            period_reg    <= period_next;
            schmitt_reg   <= schmitt_next;
            edge_reg      <= edge_next;
            elapsed_reg   <= elapsed_next;
            active_reg    <= active_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cv_reg    <= cv_next;
        acc_reg   <= acc_next;
        mcand_reg <= mcand_next;
        dur_reg   <= dur_next;
        ramp_reg  <= ramp_next;
        gate_reg  <= gate_next;
    end

    trg_div #(
        .RAMP_BITS (RAMP_BITS)
    ) u_div (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (div_ctl),
        .elapsed (elapsed_reg[DUR_BITS-1:0]),
        .den     (dur_reg),
        .stat    (div_stat),
        .quot    (div_quot)
    );

    assign sample.ready      = (state_reg == S_IDLE);
    assign cfg.ready         = 1'b1;
    assign result.valid      = out_valid_reg;
    assign result.ramp_level = ramp_reg;
    assign result.gate       = gate_reg;

    `TRG_ASSERT_NEXT(a_take_starts_mul, clk, rst_n, take, state_reg == S_MUL,
        "accepted item did not start the product")
    `TRG_ASSERT(a_active_below_dur, clk, rst_n, (state_reg == S_FIN) && active_reg,
        elapsed_reg < TIME_BITS'(dur_reg), "active pulse past its duration")
    `TRG_ASSERT(a_gate_low_ramp_zero, clk, rst_n, out_valid_reg && !gate_reg,
        ramp_reg == '0, "ramp nonzero with gate low")
    `TRG_ASSERT(a_div_only_in_div, clk, rst_n, div_stat.busy,
        (state_reg == S_DIV), "divider busy outside the divide phase")

endmodule

// ===== sv/trg_div.sv =====
// Bit-serial restoring divider for the ramp ratio elapsed * (2^R - 1) / duration.
`include "assert_macros.svh"
module trg_div import trg_pkg::*; #(
    parameter int RAMP_BITS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  div_ctl_t              ctl,
    input  logic [DUR_BITS-1:0]   elapsed,
    input  logic [DUR_BITS-1:0]   den,
    output div_stat_t             stat,
    output logic [RAMP_BITS-1:0]  quot
);

    localparam int NUM_BITS = DUR_BITS + RAMP_BITS;
    localparam int CNT_BITS = $clog2(RAMP_BITS);

    logic                 busy_reg, busy_next;
    logic [CNT_BITS-1:0]  cnt_reg, cnt_next;
    logic [DUR_BITS-1:0]  rem_reg, rem_next;
    logic [DUR_BITS-1:0]  den_reg, den_next;
    logic [RAMP_BITS-1:0] low_reg, low_next;
    logic [RAMP_BITS-1:0] q_reg, q_next;

    logic [NUM_BITS-1:0]  num;
    logic [DUR_BITS:0]    trial;
    logic [DUR_BITS:0]    diff;
    logic                 fits;

    assign num   = {elapsed, {RAMP_BITS{1'b0}}} - NUM_BITS'(elapsed);
    assign trial = {rem_reg, low_reg[RAMP_BITS-1]};
    assign diff  = trial - {1'b0, den_reg};
    assign fits  = (trial >= {1'b0, den_reg});

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        low_next  = low_reg;
        q_next    = q_reg;
        if (ctl.start)
        begin
            // the top part of the numerator is already below the divisor
            busy_next = 1'b1;
            cnt_next  = CNT_BITS'(RAMP_BITS - 1);
            rem_next  = num[NUM_BITS-1:RAMP_BITS];
            low_next  = num[RAMP_BITS-1:0];
            den_next  = den;
        end
        else if (busy_reg)
        begin
            rem_next = fits ? diff[DUR_BITS-1:0] : trial[DUR_BITS-1:0];
            low_next = {low_reg[RAMP_BITS-2:0], 1'b0};
            q_next   = {q_reg[RAMP_BITS-2:0], fits};
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        den_reg <= den_next;
        low_reg <= low_next;
        q_reg   <= q_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = busy_reg && (cnt_reg == '0);
    assign quot      = q_reg;

    `TRG_ASSERT_NEXT(a_div_start_busy, clk, rst_n, ctl.start, busy_reg,
        "divider did not start")
    `TRG_ASSERT(a_div_rem_below_den, clk, rst_n, busy_reg, rem_reg < den_reg,
        "partial remainder not below divisor")
    `TRG_ASSERT_NEXT(a_div_done_idle, clk, rst_n, stat.done && !ctl.start, !busy_reg,
        "divider still busy after last step")

endmodule

// ===== dv/ramp_gate_check.sv =====
// Watches the ramp generator channels, predicts every result item and compares it.
`timescale 1ns / 100ps
module ramp_gate_check import trg_pkg::*; #(
    parameter int RAMP_BITS = 16,
    parameter int TIME_BITS = 40
) (
    input  logic clk,
    input  logic rst_n,
    trg_in_if    sample,
    trg_out_if   result,
    trg_cfg_if   cfg,
    output int   mismatches,
    output int   outstanding
);

    typedef struct packed {
        logic [RAMP_BITS-1:0] level;
        logic                 gate;
    } ramp_item_t;

    localparam longint unsigned TIME_MAX   = (64'd1 << TIME_BITS) - 64'd1;
    localparam longint unsigned LEVEL_FULL = (64'd1 << RAMP_BITS) - 64'd1;

    // Register copies
    logic [BASE_BITS-1:0]          base_ns;
    logic signed [GAIN_BITS-1:0]   gain_ns_per_mv;
    logic [PERIOD_BITS-1:0]        period_ns;

    // Pulse state
    logic            trig_high;
    longint unsigned elapsed_ns;
    logic            pulse_on;

    ramp_item_t pending_levels[$];

    // Advance the pulse state by one sample and return the item it yields.
    function automatic ramp_item_t next_ramp_sample(logic signed [MV_BITS-1:0] trig,
                                                    logic signed [MV_BITS-1:0] cv);
        logic            rise;
        longint          dur;
        longint unsigned span;
        longint unsigned level;
        ramp_item_t      item;
        rise = 1'b0;
        if (trig_high) begin
            if (trig <= TRIG_LOW_MV)
                trig_high = 1'b0;
        end
        else if (trig >= TRIG_HIGH_MV) begin
            trig_high = 1'b1;
            rise = 1'b1;
        end
        dur = longint'(base_ns) + longint'(cv) * longint'(gain_ns_per_mv);
        if (dur < 0)
            dur = 0;
        if (dur > longint'(MAX_DUR_NS))
            dur = longint'(MAX_DUR_NS);
        span = unsigned'(dur);
        if (rise && span != 0) begin
            elapsed_ns = 0;
            pulse_on = 1'b1;
        end
        // saturate rather than wrap
        if (elapsed_ns > TIME_MAX - 64'(period_ns))
            elapsed_ns = TIME_MAX;
        else
            elapsed_ns += 64'(period_ns);
        if (pulse_on && elapsed_ns >= span)
            pulse_on = 1'b0;
        level = 0;
        if (pulse_on && span != 0) begin
            level = elapsed_ns * LEVEL_FULL / span;
            if (level > LEVEL_FULL)
                level = LEVEL_FULL;
        end
        item.level = level[RAMP_BITS-1:0];
        item.gate = pulse_on;
        return item;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        ramp_item_t want;
        if (!rst_n) begin
            base_ns = BASE_RESET;
            gain_ns_per_mv = '0;
            period_ns = PERIOD_RESET;
            trig_high = 1'b0;
            elapsed_ns = 0;
            pulse_on = 1'b0;
            pending_levels.delete();
            mismatches = 0;
            outstanding = 0;
        end
        else begin
            if (cfg.valid && cfg.ready) begin
                case (cfg.index)
                    REG_BASE:   base_ns = cfg.data[BASE_BITS-1:0];
                    REG_GAIN:   gain_ns_per_mv = cfg.data[GAIN_BITS-1:0];
                    REG_PERIOD: period_ns = cfg.data[PERIOD_BITS-1:0];
                    default:    ;
                endcase
            end
            // compare before pushing so a stray item never meets its own prediction
            if (result.valid && result.ready) begin
                if (pending_levels.size() == 0) begin
                    if (mismatches < 10)
                        $display("%0t: result item with nothing expected: level %0d gate %0b",
                                 $realtime, result.ramp_level, result.gate);
                    mismatches++;
                end
                else begin
                    want = pending_levels.pop_front();
                    if (result.ramp_level !== want.level || result.gate !== want.gate) begin
                        if (mismatches < 10)
                            $display("%0t: want level %0d gate %0b, got level %0d gate %0b",
                                     $realtime, want.level, want.gate,
                                     result.ramp_level, result.gate);
                        mismatches++;
                    end
                end
            end
            if (sample.valid && sample.ready)
                pending_levels.push_back(next_ramp_sample(sample.trig_mv, sample.cv_mv));
            outstanding = pending_levels.size();
        end
    end

endmodule

// ===== dv/tb_top.sv =====
// Stimulus and verdict for the triggered ramp generator.
`timescale 1ns / 100ps
module tb_top;
    import trg_pkg::*;

    localparam int RAMP_BITS = 16;
    localparam int TIME_BITS = 40;
    localparam logic [CFG_IDX_BITS-1:0] REG_SPARE = 2'd3;
    localparam int MV_MAX = (1 << (MV_BITS - 1)) - 1;
    localparam int MV_MIN = -(1 << (MV_BITS - 1));
    localparam int GAIN_MAX = (1 << (GAIN_BITS - 1)) - 1;
    localparam int GAIN_MIN = -(1 << (GAIN_BITS - 1));
    localparam int unsigned PERIOD_MAX = (1 << PERIOD_BITS) - 1;
    localparam longint unsigned BASE_FIELD_MAX = (64'd1 << BASE_BITS) - 64'd1;
    localparam int SETTLE_CYCLES = 40;

    logic clk;
    logic rst_n;
    int   src_idle_pct;
    int   sink_idle_pct;
    int   mismatches;
    int   outstanding;

    trg_in_if                             sample_if();
    trg_out_if #(.RAMP_BITS(RAMP_BITS))   result_if();
    trg_cfg_if                            cfg_if();

    triggered_ramp_generator #(
        .RAMP_BITS(RAMP_BITS),
        .TIME_BITS(TIME_BITS)
    ) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (sample_if),
        .result (result_if),
        .cfg    (cfg_if)
    );

    ramp_gate_check #(
        .RAMP_BITS(RAMP_BITS),
        .TIME_BITS(TIME_BITS)
    ) ramp_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .sample      (sample_if),
        .result      (result_if),
        .cfg         (cfg_if),
        .mismatches  (mismatches),
        .outstanding (outstanding)
    );

    always #1 clk = ~clk;

    always @(negedge clk)
        result_if.ready <= ($urandom_range(99) >= sink_idle_pct);

    initial
    begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    function automatic logic signed [MV_BITS-1:0] rand_mv(int lo, int hi);
        return MV_BITS'(lo + int'($urandom_range(hi - lo)));
    endfunction

    task automatic send_sample(logic signed [MV_BITS-1:0] trig, logic signed [MV_BITS-1:0] cv);
        @(negedge clk);
        while ($urandom_range(99) < src_idle_pct) begin
            sample_if.valid = 1'b0;
            @(negedge clk);
        end
        sample_if.valid = 1'b1;
        sample_if.trig_mv = trig;
        sample_if.cv_mv = cv;
        do @(posedge clk); while (!sample_if.ready);
    endtask

    // Drop valid, let every item come back, then let the engine settle.
    task automatic wait_results_drained();
        @(negedge clk);
        sample_if.valid = 1'b0;
        while (outstanding != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] value);
        @(negedge clk);
        cfg_if.valid = 1'b1;
        cfg_if.index = idx;
        cfg_if.data = value;
        do @(posedge clk); while (!cfg_if.ready);
        @(negedge clk);
        cfg_if.valid = 1'b0;
    endtask

    task automatic set_phase(longint unsigned base, int gain, int unsigned period);
        wait_results_drained();
        write_reg(REG_BASE, CFG_DATA_BITS'(base));
        write_reg(REG_GAIN, CFG_DATA_BITS'(gain));
        write_reg(REG_PERIOD, CFG_DATA_BITS'(period));
    endtask

    // Trigger pulses with random levels and CV, mixed with raw noise and band values.
    task automatic send_pulse_train(int count, int cv_lo, int cv_hi);
        int sent;
        int hold;
        int rest;
        sent = 0;
        while (sent < count) begin
            if ($urandom_range(99) < 15) begin
                send_sample(MV_BITS'($urandom), MV_BITS'($urandom));
                sent++;
            end
            else begin
                hold = $urandom_range(1, 3);
                rest = $urandom_range(0, 30);
                repeat (hold) begin
                    if ($urandom_range(9) == 0)
                        send_sample(rand_mv(int'(TRIG_LOW_MV) + 1, int'(TRIG_HIGH_MV) - 1),
                                    rand_mv(cv_lo, cv_hi));
                    else
                        send_sample(rand_mv(int'(TRIG_HIGH_MV), MV_MAX), rand_mv(cv_lo, cv_hi));
                    sent++;
                end
                repeat (rest) begin
                    if ($urandom_range(9) == 0)
                        send_sample(rand_mv(int'(TRIG_LOW_MV) + 1, int'(TRIG_HIGH_MV) - 1),
                                    rand_mv(cv_lo, cv_hi));
                    else
                        send_sample(rand_mv(MV_MIN, int'(TRIG_LOW_MV)), rand_mv(cv_lo, cv_hi));
                    sent++;
                end
            end
        end
    endtask

    initial
    begin
        int unsigned period;
        clk = 1'b0;
        rst_n = 1'b0;
        sample_if.valid = 1'b0;
        sample_if.trig_mv = '0;
        sample_if.cv_mv = '0;
        cfg_if.valid = 1'b0;
        cfg_if.index = REG_BASE;
        cfg_if.data = '0;
        result_if.ready = 1'b0;
        src_idle_pct = 19;
        sink_idle_pct = 86;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Reset settings: hysteresis band, field extremes, retrigger
        send_sample(15'sd0, 15'sd0);
        send_sample(TRIG_HIGH_MV - 15'sd1, 15'sd0);
        send_sample(TRIG_HIGH_MV, 15'sd0);
        send_sample(TRIG_LOW_MV + 15'sd1, MV_BITS'(MV_MIN));
        send_sample(TRIG_LOW_MV, MV_BITS'(MV_MAX));
        send_sample(MV_BITS'(MV_MAX), -15'sd1);
        send_sample(MV_BITS'(MV_MIN), 15'sd0);
        send_sample(TRIG_HIGH_MV, 15'sd12000);
        send_sample(-15'sd12000, -15'sd12000);

        // Zero duration: the edge is ignored
        wait_results_drained();
        write_reg(REG_BASE, '0);
        send_sample(TRIG_HIGH_MV, 15'sd0);
        send_sample(15'sd0, 15'sd0);

        // Three-sample pulse that ends on its own
        wait_results_drained();
        write_reg(REG_BASE, CFG_DATA_BITS'(3 * int'(PERIOD_RESET)));
        send_sample(15'sd5000, 15'sd0);
        send_sample(15'sd5000, 15'sd0);
        send_sample(15'sd5000, 15'sd0);
        send_sample(15'sd0, 15'sd0);

        // Duration moves mid-pulse, then collapses to zero and ends it
        wait_results_drained();
        write_reg(REG_GAIN, CFG_DATA_BITS'(100));
        send_sample(TRIG_HIGH_MV, 15'sd0);
        send_sample(15'sd3000, 15'sd500);
        send_sample(15'sd3000, -15'sd625);
        send_sample(15'sd0, 15'sd0);

        // Ramps some tens of samples long
        period = $urandom_range(1000, 50000);
        set_phase(64'(period) * $urandom_range(4, 30),
                  ($urandom_range(1) ? 1 : -1) * int'($urandom_range(0, period / 200)), period);
        send_pulse_train(70, -1000, 1000);

        // Longest duration and period, most negative gain
        set_phase(64'(MAX_DUR_NS), GAIN_MIN, PERIOD_MAX);
        send_pulse_train(70, -100, 12000);

        src_idle_pct = 86;
        sink_idle_pct = 19;
        // Base beyond ten seconds, largest gain
        set_phase(BASE_FIELD_MAX, GAIN_MAX, 1000000);
        send_pulse_train(70, MV_MIN, MV_MIN + 44);

        // Duration set by CV alone
        set_phase(0, 1000000, $urandom_range(200000, 1000000));
        send_pulse_train(70, -10, 60);

        src_idle_pct = 0;
        sink_idle_pct = 0;
        // Elapsed time frozen; a shrinking duration ends the pulse
        set_phase($urandom_range(1, 100000000), -1000000, 0);
        send_pulse_train(70, -100, 100);

        // Shortest nonzero period and tiny durations; the spare index must change nothing
        set_phase($urandom_range(1, 40), 0, 1);
        write_reg(REG_SPARE, CFG_DATA_BITS'({$urandom, $urandom}));
        send_pulse_train(70, MV_MIN, MV_MAX);

        wait_results_drained();
        if (mismatches == 0 && outstanding == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
